>>> src/ghre_pkg.sv
// Shared types and constants for the grid histogram range estimate unit.
// Depends on nothing; used by every module of the block but ghre_div.
package ghre_pkg;

   // Item kinds carried in req_tuser
   localparam logic [1:0] OP_LOAD_COL  = 2'd0;
   localparam logic [1:0] OP_LOAD_ROW  = 2'd1;
   localparam logic [1:0] OP_LOAD_CELL = 2'd2;
   localparam logic [1:0] OP_QUERY     = 2'd3;

   // Register indexes on the csr port
   localparam logic CSR_COLS_IN_USE = 1'b0;
   localparam logic CSR_ROWS_IN_USE = 1'b1;

   localparam int CFG_W   = 9;
   localparam int COORD_W = 32;
   localparam int COUNT_W = 32;

   // 0.00001 in Q32.32, added before truncation
   localparam logic [63:0] EPS_Q32 = 64'd42950;

   // Controller to datapath commands
   typedef struct packed {
      logic start_query;
      logic scan;
      logic clamp;
      logic col_rd;
      logic cell_rd;
      logic div_start;
      logic mul_frac;
      logic mul_add;
      logic accum;
      logic next_cell;
      logic next_col;
      logic finish;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic span_empty;
      logic col_ok;
      logic cell_use;
      logic div_busy;
      logic last_y;
      logic last_x;
      logic out_free;
   } status_type;

endpackage

>>> src/grid_histogram_range_estimate_unit.sv
// Top level of the grid histogram range estimate unit: ports, csr registers,
// controller and datapath. Depends on ghre_pkg, ghre_ctrl and ghre_datapath.
//
//   channel  direction  transfer carries
//   req_     in         tuser: op; tdata: load fields or query rectangle
//   rsp_     out        tdata: estimate; tuser: saturated flag
//   csr_     in         write of cols_in_use / rows_in_use
//
// Loads are taken while idle. A query runs the bound scan (one memory read a
// cycle) and the result, plus per column of the span a column read and, per
// cell of a usable column, the one-bit-a-cycle divider when a fraction needs it,
// a short path when both fractions are 0 or 1, and a skip for an unused cell.
// Reset is synchronous and clears control state only; memories are not cleared.
// A finished result waits in the output register while the next item is taken;
// a further query holds in its last state until that register is free.
module grid_histogram_range_estimate_unit #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // col_index[7:0], row_index[15:8], bound_low[47:16], bound_high[79:48],
   // cell_count_in[111:80], q_min_x[143:112], q_min_y[175:144],
   // q_max_x[207:176], q_max_y[239:208]
   input  logic [239:0] req_tdata,
   // op[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // estimate[31:0]
   output logic [31:0]  rsp_tdata,
   // saturated[0]
   output logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [8:0]   csr_wdata
);

   logic [ghre_pkg::CFG_W-1:0] cols_in_use_ff, rows_in_use_ff;
   ghre_pkg::cmd_type    cmd;
   ghre_pkg::status_type status;
   logic req_accept;
   logic sat_bit;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_in_use_ff <= ghre_pkg::CFG_W'(1);
         rows_in_use_ff <= ghre_pkg::CFG_W'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            ghre_pkg::CSR_COLS_IN_USE: cols_in_use_ff <= csr_wdata;
            ghre_pkg::CSR_ROWS_IN_USE: rows_in_use_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_accept = req_tvalid && req_tready;

   ghre_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ghre_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_accept    (req_accept),
      .req_op        (req_tuser),
      .col_index     (req_tdata[7:0]),
      .row_index     (req_tdata[15:8]),
      .bound_low     (req_tdata[47:16]),
      .bound_high    (req_tdata[79:48]),
      .cell_count_in (req_tdata[111:80]),
      .q_min_x       (req_tdata[143:112]),
      .q_min_y       (req_tdata[175:144]),
      .q_max_x       (req_tdata[207:176]),
      .q_max_y       (req_tdata[239:208]),
      .cols_in_use   (cols_in_use_ff),
      .rows_in_use   (rows_in_use_ff),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .estimate      (rsp_tdata),
      .saturated     (sat_bit)
   );

   assign rsp_tuser = sat_bit;

endmodule

>>> src/ghre_div.sv
// Restoring divider: overlap * 2^32 / extent as unsigned Q1.32, one bit a cycle.
// Depends on nothing; instantiated twice by ghre_datapath.
module ghre_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] overlap,
   input  logic signed [32:0] extent,
   output logic               busy,
   output logic [32:0]        quotient
);

   logic        busy_ff, busy_in;
   logic        quick_ff, quick_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] ext_ff, ext_in;
   logic [32:0] quo_ff, quo_in;
   logic [32:0] rem_dbl;

   assign rem_dbl = {rem_ff, 1'b0};

   // one quotient bit per cycle; full or empty overlap is settled at start
   always_comb begin
      busy_in  = busy_ff;
      quick_in = quick_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      ext_in   = ext_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         ext_in  = extent[31:0];
         rem_in  = overlap[31:0];
         quo_in  = '0;
         if (overlap <= 33'sd0) begin
            quick_in = 1'b1;
         end else if (overlap >= extent) begin
            quick_in = 1'b1;
            quo_in   = 33'h1_0000_0000;
         end else begin
            quick_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (quick_ff) begin
            busy_in = 1'b0;
         end else begin
            if (rem_dbl >= {1'b0, ext_ff}) begin
               rem_in = 32'(rem_dbl - {1'b0, ext_ff});
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = rem_dbl[31:0];
               quo_in = {quo_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      quick_ff <= quick_in;
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      ext_ff   <= ext_in;
      quo_ff   <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

>>> src/ghre_datapath.sv
// Datapath: bound and count memories, scan counters, cell walk, fraction maths,
// accumulator and result register. Depends on ghre_pkg and ghre_div.
module ghre_datapath #(
   parameter int MAX_COLUMNS = 256,
   parameter int MAX_ROWS    = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ghre_pkg::cmd_type        cmd,
   output ghre_pkg::status_type     status,
   input  logic                     req_accept,
   input  logic [1:0]               req_op,
   input  logic [7:0]               col_index,
   input  logic [7:0]               row_index,
   input  logic signed [31:0]       bound_low,
   input  logic signed [31:0]       bound_high,
   input  logic [31:0]              cell_count_in,
   input  logic signed [31:0]       q_min_x,
   input  logic signed [31:0]       q_min_y,
   input  logic signed [31:0]       q_max_x,
   input  logic signed [31:0]       q_max_y,
   input  logic [ghre_pkg::CFG_W-1:0] cols_in_use,
   input  logic [ghre_pkg::CFG_W-1:0] rows_in_use,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic [31:0]              estimate,
   output logic                     saturated
);

   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int MAXN  = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int SW    = $clog2(MAXN) + 1;
   localparam int CELLS = 2 ** (CW + RW);

   // Memories
   logic signed [31:0] col_start_mem [2**CW];
   logic signed [31:0] col_end_mem   [2**CW];
   logic signed [31:0] row_start_mem [2**RW];
   logic signed [31:0] row_end_mem   [2**RW];
   logic [31:0]        cell_mem      [CELLS];

   logic signed [31:0] cx0_q, cx1_q, cy0_q, cy1_q;
   logic [31:0]        count_q;

   // Query and walk registers
   logic signed [31:0] qx0_ff, qy0_ff, qx1_ff, qy1_ff;
   logic [SW-1:0]      sidx_ff, sidx_d_ff;
   logic               sv_ff;
   logic [CW:0]        x0c_ff, x1c_ff;
   logic [RW:0]        y0c_ff, y1c_ff;
   logic [CW-1:0]      xi_ff, xi_in, xend_ff;
   logic [RW-1:0]      yi_ff, yi_in, ystart_ff, yend_ff;
   logic [32:0]        frac_ff, frac_in;
   logic [63:0]        add_ff, add_in;
   logic [63:0]        acc_ff;
   logic               sat_ff;
   logic               out_valid_ff;
   logic [31:0]        est_ff;
   logic               osat_ff;

   // Effective grid size
   logic [CW:0]   cols_eff;
   logic [RW:0]   rows_eff;
   logic [SW-1:0] nscan;

   always_comb begin
      if (cols_in_use == '0) begin
         cols_eff = (CW+1)'(1);
      end else if (32'(cols_in_use) > 32'(MAX_COLUMNS)) begin
         cols_eff = (CW+1)'(MAX_COLUMNS);
      end else begin
         cols_eff = (CW+1)'(cols_in_use);
      end
      if (rows_in_use == '0) begin
         rows_eff = (RW+1)'(1);
      end else if (32'(rows_in_use) > 32'(MAX_ROWS)) begin
         rows_eff = (RW+1)'(MAX_ROWS);
      end else begin
         rows_eff = (RW+1)'(rows_in_use);
      end
      nscan = (SW'(cols_eff) > SW'(rows_eff)) ? SW'(cols_eff) : SW'(rows_eff);
   end

   // Memory write and read ports
   logic          wr_col, wr_row, wr_cell;
   logic [CW-1:0] col_rd_addr;
   logic [RW-1:0] row_rd_addr;

   assign wr_col  = req_accept && (req_op == ghre_pkg::OP_LOAD_COL)
                    && (32'(col_index) < 32'(MAX_COLUMNS));
   assign wr_row  = req_accept && (req_op == ghre_pkg::OP_LOAD_ROW)
                    && (32'(row_index) < 32'(MAX_ROWS));
   assign wr_cell = req_accept && (req_op == ghre_pkg::OP_LOAD_CELL)
                    && (32'(col_index) < 32'(MAX_COLUMNS))
                    && (32'(row_index) < 32'(MAX_ROWS));
   assign col_rd_addr = cmd.scan ? sidx_ff[CW-1:0] : xi_ff;
   assign row_rd_addr = cmd.scan ? sidx_ff[RW-1:0] : yi_ff;

   always_ff @(posedge clock) begin
      if (wr_col) begin
         col_start_mem[CW'(col_index)] <= bound_low;
         col_end_mem[CW'(col_index)]   <= bound_high;
      end
      if (cmd.scan || cmd.col_rd) begin
         cx0_q <= col_start_mem[col_rd_addr];
         cx1_q <= col_end_mem[col_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_row) begin
         row_start_mem[RW'(row_index)] <= bound_low;
         row_end_mem[RW'(row_index)]   <= bound_high;
      end
      if (cmd.scan || cmd.cell_rd) begin
         cy0_q <= row_start_mem[row_rd_addr];
         cy1_q <= row_end_mem[row_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cell) begin
         cell_mem[{CW'(col_index), RW'(row_index)}] <= cell_count_in;
      end
      if (cmd.cell_rd) begin
         count_q <= cell_mem[{xi_ff, yi_ff}];
      end
   end

   // Clamped span from the scan counts
   logic [CW-1:0] x0_cl, x1_cl;
   logic [RW-1:0] y0_cl, y1_cl;

   always_comb begin
      x0_cl = (x0c_ff == '0) ? '0 : CW'(x0c_ff - (CW+1)'(1));
      y0_cl = (y0c_ff == '0) ? '0 : RW'(y0c_ff - (RW+1)'(1));
      x1_cl = (x1c_ff >= cols_eff) ? CW'(cols_eff - (CW+1)'(1)) : CW'(x1c_ff);
      y1_cl = (y1c_ff >= rows_eff) ? RW'(rows_eff - (RW+1)'(1)) : RW'(y1c_ff);
   end

   // Cell geometry
   logic signed [31:0] ix_hi, ix_lo, iy_hi, iy_lo;
   logic signed [32:0] ov_x, ov_y, cw, ch;
   logic               col_ok, cell_use;

   always_comb begin
      ix_hi = (qx1_ff < cx1_q) ? qx1_ff : cx1_q;
      ix_lo = (qx0_ff > cx0_q) ? qx0_ff : cx0_q;
      iy_hi = (qy1_ff < cy1_q) ? qy1_ff : cy1_q;
      iy_lo = (qy0_ff > cy0_q) ? qy0_ff : cy0_q;
      ov_x  = {ix_hi[31], ix_hi} - {ix_lo[31], ix_lo};
      ov_y  = {iy_hi[31], iy_hi} - {iy_lo[31], iy_lo};
      cw    = {cx1_q[31], cx1_q} - {cx0_q[31], cx0_q};
      ch    = {cy1_q[31], cy1_q} - {cy0_q[31], cy0_q};
      col_ok   = !cw[32] && (cw != '0);
      cell_use = !ch[32] && (ch != '0)
                 && (qx0_ff <= cx1_q) && (qy0_ff <= cy1_q)
                 && (cx0_q <= qx1_ff) && (cy0_q <= qy1_ff);
   end

   // Fraction dividers, one per axis
   logic        busy_x, busy_y;
   logic [32:0] fx, fy;

   ghre_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .overlap  (ov_x),
      .extent   (cw),
      .busy     (busy_x),
      .quotient (fx)
   );

   ghre_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .overlap  (ov_y),
      .extent   (ch),
      .busy     (busy_y),
      .quotient (fy)
   );

   // Area fraction, then count times fraction
   logic [63:0] fxy;
   assign fxy = fx[31:0] * fy[31:0];

   always_comb begin
      if (fx[32]) begin
         frac_in = fy;
      end else if (fy[32]) begin
         frac_in = fx;
      end else begin
         frac_in = {1'b0, fxy[63:32]};
      end
      if (frac_ff[32]) begin
         add_in = {count_q, 32'd0};
      end else begin
         add_in = count_q * frac_ff[31:0];
      end
   end

   // Walk indices
   always_comb begin
      xi_in = xi_ff;
      yi_in = yi_ff;
      if (cmd.clamp) begin
         xi_in = x0_cl;
         yi_in = y0_cl;
      end else if (cmd.next_col) begin
         xi_in = xi_ff + CW'(1);
         yi_in = ystart_ff;
      end else if (cmd.next_cell) begin
         yi_in = yi_ff + RW'(1);
      end
   end

   logic [64:0] acc_sum, fin_sum;
   assign acc_sum = {1'b0, acc_ff} + {1'b0, add_ff};
   assign fin_sum = {1'b0, acc_ff} + {1'b0, ghre_pkg::EPS_Q32};

   // Payload and walk registers
   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         qx0_ff <= q_min_x;
         qy0_ff <= q_min_y;
         qx1_ff <= q_max_x;
         qy1_ff <= q_max_y;
         sidx_ff <= '0;
         x0c_ff <= '0;
         x1c_ff <= '0;
         y0c_ff <= '0;
         y1c_ff <= '0;
         acc_ff <= '0;
         sat_ff <= 1'b0;
      end else begin
         if (cmd.scan) begin
            sidx_ff <= sidx_ff + SW'(1);
         end
         // count bounds read in the previous cycle
         if (sv_ff) begin
            if (sidx_d_ff < SW'(cols_eff)) begin
               if (cx0_q <= qx0_ff) x0c_ff <= x0c_ff + (CW+1)'(1);
               if (cx1_q < qx1_ff)  x1c_ff <= x1c_ff + (CW+1)'(1);
            end
            if (sidx_d_ff < SW'(rows_eff)) begin
               if (cy0_q <= qy0_ff) y0c_ff <= y0c_ff + (RW+1)'(1);
               if (cy1_q < qy1_ff)  y1c_ff <= y1c_ff + (RW+1)'(1);
            end
         end
         if (cmd.accum && !sat_ff) begin
            if (acc_sum[64]) begin
               sat_ff <= 1'b1;
            end else begin
               acc_ff <= acc_sum[63:0];
            end
         end
      end
      sidx_d_ff <= sidx_ff;
      if (cmd.clamp) begin
         xend_ff   <= x1_cl;
         yend_ff   <= y1_cl;
         ystart_ff <= y0_cl;
      end
      xi_ff <= xi_in;
      yi_ff <= yi_in;
      if (cmd.mul_frac) frac_ff <= frac_in;
      if (cmd.mul_add)  add_ff  <= add_in;
      if (cmd.finish) begin
         if (sat_ff || fin_sum[64]) begin
            est_ff  <= 32'hFFFF_FFFF;
            osat_ff <= 1'b1;
         end else begin
            est_ff  <= fin_sum[63:32];
            osat_ff <= 1'b0;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sv_ff <= cmd.scan;
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.scan_done  = sv_ff && (sidx_d_ff == nscan - SW'(1));
   assign status.span_empty = (x0_cl > x1_cl) || (y0_cl > y1_cl);
   assign status.col_ok     = col_ok;
   assign status.cell_use   = cell_use;
   assign status.div_busy   = busy_x || busy_y;
   assign status.last_y     = (yi_ff == yend_ff);
   assign status.last_x     = (xi_ff == xend_ff);
   assign status.out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign estimate   = est_ff;
   assign saturated  = osat_ff;

endmodule

>>> src/ghre_ctrl.sv
// Controller state machine: sequences scan, clamp, cell walk and result.
// Depends on ghre_pkg.
module ghre_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [1:0]           req_op,
   output logic                 req_tready,
   input  ghre_pkg::status_type status,
   output ghre_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_CLAMP = 4'd2;
   localparam logic [3:0] S_COL   = 4'd3;
   localparam logic [3:0] S_COLW  = 4'd4;
   localparam logic [3:0] S_CELL  = 4'd5;
   localparam logic [3:0] S_CELLW = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_DIVW  = 4'd8;
   localparam logic [3:0] S_MULF  = 4'd9;
   localparam logic [3:0] S_MULA  = 4'd10;
   localparam logic [3:0] S_ACC   = 4'd11;
   localparam logic [3:0] S_NEXT  = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   logic [3:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_op == ghre_pkg::OP_QUERY)) begin
               cmd.start_query = 1'b1;
               state_in        = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = status.span_empty ? S_FIN : S_COL;
         end
         S_COL: begin
            cmd.col_rd = 1'b1;
            state_in   = S_COLW;
         end
         S_COLW: begin
            if (status.col_ok) begin
               state_in = S_CELL;
            end else if (status.last_x) begin
               state_in = S_FIN;
            end else begin
               cmd.next_col = 1'b1;
               state_in     = S_COL;
            end
         end
         S_CELL: begin
            cmd.cell_rd = 1'b1;
            state_in    = S_CELLW;
         end
         S_CELLW: begin
            state_in = status.cell_use ? S_DIV : S_NEXT;
         end
         S_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVW;
         end
         S_DIVW: begin
            if (!status.div_busy) state_in = S_MULF;
         end
         S_MULF: begin
            cmd.mul_frac = 1'b1;
            state_in     = S_MULA;
         end
         S_MULA: begin
            cmd.mul_add = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.accum = 1'b1;
            state_in  = S_NEXT;
         end
         S_NEXT: begin
            if (!status.last_y) begin
               cmd.next_cell = 1'b1;
               state_in      = S_CELL;
            end else if (!status.last_x) begin
               cmd.next_col = 1'b1;
               state_in     = S_COL;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/ghre_checker.sv
// Port-level checks for the grid histogram range estimate unit, bound to the top.
// Depends on ghre_pkg and grid_histogram_range_estimate_unit.
module ghre_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [1:0]   req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [31:0]  rsp_tdata,
   input logic [0:0]   rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // nothing is offered straight after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // a load transfer never makes a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != ghre_pkg::OP_QUERY) && !rsp_tvalid
      |=> !rsp_tvalid)
      else $error("result after a load");

   // the input side is closed in the cycle after a query is taken
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == ghre_pkg::OP_QUERY) |=> !req_tready)
      else $error("input open straight after a query");

   // a clipped estimate reads all ones
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'hFFFF_FFFF)
      else $error("saturated estimate not at maximum");

endmodule

bind grid_histogram_range_estimate_unit ghre_checker u_ghre_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> verif/ghre_estimate_checker.sv
`timescale 1ns / 100ps
// Checker for the grid histogram range estimate unit: watches the csr, req_ and
// rsp_ channels, predicts every estimate and compares it. Depends on ghre_pkg.
module ghre_estimate_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [239:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [31:0]  rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [8:0]   csr_wdata,
   output int           outstanding,
   output int           mismatch_count,
   output int           saturated_seen
);

   typedef struct packed {
      logic [31:0] estimate;
      logic        saturated;
   } estimate_type;

   localparam int GRID_MAX = 256;
   localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

   // Histogram copy kept by the checker
   logic signed [31:0] col_lo_mem [GRID_MAX];
   logic signed [31:0] col_hi_mem [GRID_MAX];
   logic signed [31:0] row_lo_mem [GRID_MAX];
   logic signed [31:0] row_hi_mem [GRID_MAX];
   logic [31:0]        count_mem  [GRID_MAX*GRID_MAX];
   logic [8:0]         cols_reg;
   logic [8:0]         rows_reg;
   estimate_type       estimates_due [$];

   initial begin
      mismatch_count = 0;
      saturated_seen = 0;
      outstanding    = 0;
   end

   // 0 acts as 1, anything above the grid acts as the grid size
   function automatic int span_of(logic [8:0] v);
      if (v == 0) return 1;
      if (v > GRID_MAX) return GRID_MAX;
      return int'(v);
   endfunction

   // overlap / extent as unsigned Q1.32
   function automatic logic [32:0] share_q32(longint ov, longint ext);
      logic [95:0] num;
      if (ov <= 0) return '0;
      num = 96'(ov) << 32;
      return 33'(num / 96'(ext));
   endfunction

   function automatic estimate_type predict_estimate(longint qx0, longint qy0,
                                                     longint qx1, longint qy1);
      int           ncol, nrow, x0, x1, y0, y1, x, y;
      longint       cx0, cx1, cy0, cy1, cw, ch;
      logic [32:0]  fx, fy, frac;
      logic [65:0]  prod;
      logic [64:0]  acc, sum;
      logic         sat;
      estimate_type r;
      ncol = span_of(cols_reg);
      nrow = span_of(rows_reg);
      x0 = 0; x1 = 0; y0 = 0; y1 = 0;
      acc = '0;
      sat = 1'b0;
      // span search over the bounds in use
      for (x = 0; x < ncol; x++) begin
         if (longint'(col_lo_mem[x]) <= qx0) x0++;
         if (longint'(col_hi_mem[x]) < qx1) x1++;
      end
      for (y = 0; y < nrow; y++) begin
         if (longint'(row_lo_mem[y]) <= qy0) y0++;
         if (longint'(row_hi_mem[y]) < qy1) y1++;
      end
      x0--; y0--;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > ncol - 1) x1 = ncol - 1;
      if (y1 > nrow - 1) y1 = nrow - 1;
      // weighted sum over touching cells
      for (x = x0; x <= x1 && !sat; x++) begin
         cx0 = col_lo_mem[x];
         cx1 = col_hi_mem[x];
         cw  = cx1 - cx0;
         if (cw <= 0) continue;
         for (y = y0; y <= y1; y++) begin
            cy0 = row_lo_mem[y];
            cy1 = row_hi_mem[y];
            ch  = cy1 - cy0;
            if (ch <= 0) continue;
            if (!(qx0 <= cx1 && qy0 <= cy1 && cx0 <= qx1 && cy0 <= qy1)) continue;
            fx = share_q32(((qx1 < cx1) ? qx1 : cx1) - ((qx0 > cx0) ? qx0 : cx0), cw);
            fy = share_q32(((qy1 < cy1) ? qy1 : cy1) - ((qy0 > cy0) ? qy0 : cy0), ch);
            if (fx == ONE_Q32) frac = fy;
            else if (fy == ONE_Q32) frac = fx;
            else begin
               prod = 66'(fx) * 66'(fy);
               frac = 33'(prod >> 32);
            end
            sum = acc + 65'(count_mem[x*GRID_MAX + y]) * 65'(frac);
            if (sum[64]) begin
               sat = 1'b1;
               break;
            end
            acc = sum;
         end
      end
      if (!sat) begin
         sum = acc + 65'(ghre_pkg::EPS_Q32);
         if (sum[64]) sat = 1'b1;
         else acc = sum;
      end
      r.estimate  = sat ? 32'hFFFF_FFFF : acc[63:32];
      r.saturated = sat;
      return r;
   endfunction

   always @(posedge clock) begin
      estimate_type due;
      if (reset) begin
         cols_reg = 9'd1;
         rows_reg = 9'd1;
         estimates_due.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               ghre_pkg::CSR_COLS_IN_USE: cols_reg = csr_wdata;
               ghre_pkg::CSR_ROWS_IN_USE: rows_reg = csr_wdata;
               default: ;
            endcase
         end
         // result transfers against the oldest estimate
         if (rsp_tvalid && rsp_tready) begin
            if (estimates_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result %h/%b with no query waiting",
                           $realtime, rsp_tdata, rsp_tuser);
            end else begin
               due = estimates_due.pop_front();
               if (rsp_tuser[0]) saturated_seen++;
               if (rsp_tdata !== due.estimate || rsp_tuser[0] !== due.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: estimate %h sat %b, expected %h sat %b", $realtime,
                              rsp_tdata, rsp_tuser[0], due.estimate, due.saturated);
               end
            end
         end
         // request transfers
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               ghre_pkg::OP_LOAD_COL: begin
                  col_lo_mem[req_tdata[7:0]] = req_tdata[47:16];
                  col_hi_mem[req_tdata[7:0]] = req_tdata[79:48];
               end
               ghre_pkg::OP_LOAD_ROW: begin
                  row_lo_mem[req_tdata[15:8]] = req_tdata[47:16];
                  row_hi_mem[req_tdata[15:8]] = req_tdata[79:48];
               end
               ghre_pkg::OP_LOAD_CELL:
                  count_mem[{req_tdata[7:0], req_tdata[15:8]}] = req_tdata[111:80];
               ghre_pkg::OP_QUERY:
                  estimates_due.push_back(predict_estimate(
                     longint'($signed(req_tdata[143:112])),
                     longint'($signed(req_tdata[175:144])),
                     longint'($signed(req_tdata[207:176])),
                     longint'($signed(req_tdata[239:208]))));
               default: ;
            endcase
         end
      end
      outstanding <= estimates_due.size();
   end

endmodule

>>> verif/tb_grid_histogram_range_estimate_unit.sv
`timescale 1ns / 100ps
// Testbench top for grid_histogram_range_estimate_unit: loads grids, issues
// queries under random idling and gives the verdict from ghre_estimate_checker.
module tb_grid_histogram_range_estimate_unit;

   localparam int  CYCLE_LIMIT = 10_000_000;
   localparam int  GRID_MAX    = 256;
   localparam longint MARGIN   = 64'h10000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [239:0] req_tdata = '0;
   logic [1:0]   req_tuser = ghre_pkg::OP_LOAD_COL;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we = 1'b0;
   logic         csr_addr = ghre_pkg::CSR_COLS_IN_USE;
   logic [8:0]   csr_wdata = '0;

   int           outstanding, mismatch_count, saturated_seen;
   logic         req_taken = 1'b0;
   logic         calm = 1'b0;
   int           cycle_count = 0;
   int           load_total = 0, query_total = 0, setting_total = 0;

   // bounds as loaded, used to aim the queries
   longint       x_lo [GRID_MAX], x_hi [GRID_MAX], y_lo [GRID_MAX], y_hi [GRID_MAX];

   grid_histogram_range_estimate_unit i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_addr, .csr_wdata
   );

   ghre_estimate_checker i_checker (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_addr, .csr_wdata,
      .outstanding, .mismatch_count, .saturated_seen
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) req_taken <= req_tvalid && req_tready;

   // receiver stalls
   always @(negedge clock)
      rsp_tready <= calm || ($urandom_range(0, 99) >= 14);

   // Starts at a negedge; returns at the negedge after the transfer, valid still high
   task automatic send_item(input logic [1:0] op, input logic [239:0] data);
      if (!calm && $urandom_range(0, 99) < 14) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(negedge clock); while (!req_taken);
      if (op == ghre_pkg::OP_QUERY) query_total++;
      else load_total++;
   endtask

   task automatic load_col(input int x, input longint lo, input longint hi);
      x_lo[x] = lo;
      x_hi[x] = hi;
      send_item(ghre_pkg::OP_LOAD_COL,
                {160'($urandom()), 32'(hi), 32'(lo), 8'($urandom()), 8'(x)});
   endtask

   task automatic load_row(input int y, input longint lo, input longint hi);
      y_lo[y] = lo;
      y_hi[y] = hi;
      send_item(ghre_pkg::OP_LOAD_ROW,
                {160'($urandom()), 32'(hi), 32'(lo), 8'(y), 8'($urandom())});
   endtask

   task automatic load_cell(input int x, input int y, input logic [31:0] cnt);
      send_item(ghre_pkg::OP_LOAD_CELL,
                {128'({$urandom(), $urandom(), $urandom(), $urandom()}),
                 cnt, 64'({$urandom(), $urandom()}), 8'(y), 8'(x)});
   endtask

   task automatic query(input longint qx0, input longint qy0,
                        input longint qx1, input longint qy1);
      send_item(ghre_pkg::OP_QUERY, {32'(qy1), 32'(qx1), 32'(qy0), 32'(qx0),
                           96'({$urandom(), $urandom(), $urandom()}), 16'($urandom())});
   endtask

   // Drop valid, wait for every estimate, then let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic program_grid(input logic [8:0] ncol, input logic [8:0] nrow);
      settle();
      setting_total++;
      csr_we    <= 1'b1;
      csr_addr  <= ghre_pkg::CSR_COLS_IN_USE;
      csr_wdata <= ncol;
      @(negedge clock);
      csr_addr  <= ghre_pkg::CSR_ROWS_IN_USE;
      csr_wdata <= nrow;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic longint random_extent();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return -longint'($urandom_range(1, 32'h8000));
         default: return longint'($urandom_range(1, 32'h40000));
      endcase
   endfunction

   function automatic logic [31:0] random_count();
      case ($urandom_range(0, 19))
         0:       return 32'hFFFF_FFFF;
         1, 2:    return $urandom();
         3:       return 32'd0;
         default: return $urandom_range(1, 1000);
      endcase
   endfunction

   // Fresh bounds for every column and row in use, then every cell
   task automatic load_grid(input int ncol, input int nrow);
      longint pos, w;
      pos = longint'($urandom_range(0, 32'h4000_0000)) - 64'h2000_0000;
      for (int x = 0; x < ncol; x++) begin
         w = random_extent();
         load_col(x, pos, pos + w);
         if (w > 0) pos += w;
      end
      pos = longint'($urandom_range(0, 32'h4000_0000)) - 64'h2000_0000;
      for (int y = 0; y < nrow; y++) begin
         w = random_extent();
         load_row(y, pos, pos + w);
         if (w > 0) pos += w;
      end
      for (int x = 0; x < ncol; x++)
         for (int y = 0; y < nrow; y++)
            load_cell(x, y, random_count());
   endtask

   // Coordinate somewhere around the given bounds, Q16.16
   function automatic longint aim(input longint lo, input longint hi);
      if (hi - lo > 64'h4000_0000 || lo < -64'h7000_0000 || hi > 64'h7000_0000)
         return longint'($signed($urandom()));
      return lo - MARGIN + longint'($urandom_range(0, 32'(hi - lo + 2*MARGIN)));
   endfunction

   task automatic random_query(input int ncol, input int nrow);
      longint xmin, xmax, ymin, ymax, a, b, c, d;
      if ($urandom_range(0, 14) == 0) begin
         query($signed($urandom()), $signed($urandom()),
               $signed($urandom()), $signed($urandom()));
         return;
      end
      xmin = x_lo[0]; xmax = x_hi[0]; ymin = y_lo[0]; ymax = y_hi[0];
      for (int x = 0; x < ncol; x++) begin
         if (x_lo[x] < xmin) xmin = x_lo[x];
         if (x_hi[x] < xmin) xmin = x_hi[x];
         if (x_lo[x] > xmax) xmax = x_lo[x];
         if (x_hi[x] > xmax) xmax = x_hi[x];
      end
      for (int y = 0; y < nrow; y++) begin
         if (y_lo[y] < ymin) ymin = y_lo[y];
         if (y_hi[y] < ymin) ymin = y_hi[y];
         if (y_lo[y] > ymax) ymax = y_lo[y];
         if (y_hi[y] > ymax) ymax = y_hi[y];
      end
      a = aim(xmin, xmax); b = aim(xmin, xmax);
      c = aim(ymin, ymax); d = aim(ymin, ymax);
      // mostly well-ordered rectangles, some inverted
      if ($urandom_range(0, 9) != 0) begin
         if (a > b) begin xmin = a; a = b; b = xmin; end
         if (c > d) begin ymin = c; c = d; d = ymin; end
      end
      query(a, c, b, d);
   endtask

   initial begin
      int ncol, nrow, phase, n;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: coordinate extremes, saturation, zero-height row, edge cases
      program_grid(9'd2, 9'd2);
      load_col(0, -64'h8000_0000, 0);
      load_col(1, 0, 64'h7FFF_FFFF);
      load_row(0, 0, 64'h10000);
      load_row(1, 64'h10000, 64'h10000);
      load_cell(0, 0, 32'hFFFF_FFFF);
      load_cell(1, 0, 32'hFFFF_FFFF);
      load_cell(0, 1, 32'd5);
      load_cell(1, 1, 32'd0);
      query(-64'h8000_0000, -64'h8000_0000, 64'h7FFF_FFFF, 64'h7FFF_FFFF);
      query(64'h7FFF_FFFF, 64'h7FFF_FFFF, -64'h8000_0000, -64'h8000_0000);
      query(0, 0, 64'h7FFF_FFFF, 64'h10000);
      query(-64'h4000_0000, 64'h8000, -64'h4000_0000, 64'h8000);
      query(-64'h100, 0, 0, 64'h8000);
      query(0, 64'h20000, 64'h100, 64'h30000);
      load_cell(0, 0, 32'd7);
      load_cell(1, 0, 32'd1);
      query(-64'h8000_0000, 0, 64'h7FFF_FFFF, 64'h10000);
      query(-64'h1000, 64'h1000, 64'h1000, 64'hF000);

      // widest grid across the columns, with out-of-range register values
      program_grid(9'd511, 9'd0);
      load_grid(GRID_MAX, 1);
      repeat (6) random_query(GRID_MAX, 1);

      // random phases on small grids
      phase = 0;
      while (load_total + query_total < 950) begin
         phase++;
         ncol = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         nrow = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         program_grid((ncol == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(ncol),
                      (nrow == 1 && $urandom_range(0, 1)) ? 9'd0 : 9'(nrow));
         calm = (phase % 4 == 1);
         load_grid(ncol, nrow);
         n = $urandom_range(20, 50);
         for (int i = 0; i < n; i++) begin
            if (phase == 3 && i == n / 2) settle();
            case ($urandom_range(0, 9))
               7: load_col($urandom_range(0, ncol - 1), 0, 0);
               8: load_cell($urandom_range(0, ncol - 1), $urandom_range(0, nrow - 1),
                            random_count());
               9: begin
                  // stray loads anywhere in the grid store
                  if ($urandom_range(0, 1))
                     load_row($urandom_range(0, GRID_MAX - 1), $signed($urandom()),
                              $signed($urandom()));
                  else
                     load_cell($urandom_range(0, GRID_MAX - 1),
                               $urandom_range(0, GRID_MAX - 1), $urandom());
               end
               default: random_query(ncol, nrow);
            endcase
         end
         calm = 1'b0;
      end

      settle();
      repeat (50) @(negedge clock);
      $display("Covered %0d loads and %0d queries over %0d grid settings;",
               load_total, query_total, setting_total);
      $display("%0d estimates saturated, %0d mismatches.", saturated_seen, mismatch_count);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
